[src/bptc_pkg.sv]
`default_nettype none

package bptc_pkg;

	// Field widths of the channels and the calibration words.
	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int TEMP_W  = 15;
	localparam int PRESS_W = 17;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SENS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TCS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TCO      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TREF     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPSENS = 3'd5;

	// Internal word widths, sized to the value ranges they carry.
	localparam int DT_W    = RAW_W + 1;
	localparam int MULT_W  = DT_W + COEF_W + 1;
	localparam int DTSQ_W  = 2 * RAW_W;
	localparam int T2_W    = DTSQ_W - 31;
	localparam int TEMP1_W = 20;
	localparam int OFF1_W  = 35;
	localparam int SENS1_W = 34;
	localparam int SQ_W    = 35;
	localparam int CORR_W  = 39;
	localparam int OFF_W   = 40;
	localparam int SENS_W  = 40;
	localparam int SPLIT_W = 20;
	localparam int PLO_W   = RAW_W + SPLIT_W;
	localparam int PHI_W   = RAW_W + 1 + SENS_W - SPLIT_W;
	localparam int PROD_W  = 64;
	localparam int X_W     = 44;

	// Pipeline depth.
	localparam int NSTAGE = 9;

	// Temperature thresholds and limits in hundredths of a degree.
	localparam logic signed [TEMP1_W-1:0] TEMP_REF  = TEMP1_W'(2000);
	localparam logic signed [TEMP1_W-1:0] TEMP_DEEP = TEMP1_W'(-1500);
	localparam logic signed [TEMP1_W-1:0] TEMP_LO   = TEMP1_W'(-4000);
	localparam logic signed [TEMP1_W-1:0] TEMP_HI   = TEMP1_W'(8500);

	localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};

endpackage

`default_nettype wire

[src/bptc_ifs.sv]
`default_nettype none

interface bptc_in_if;
	import bptc_pkg::*;

	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_temp;
	logic [RAW_W-1:0] raw_press;

	modport source (output valid, output raw_temp, output raw_press, input ready);
	modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface

interface bptc_out_if;
	import bptc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [TEMP_W-1:0]  temp_centi;
	logic        [PRESS_W-1:0] press_pa;
	logic                      clipped;

	modport source (output valid, output temp_centi, output press_pa, output clipped,
		input ready);
	modport sink (input valid, input temp_centi, input press_pa, input clipped,
		output ready);
endinterface

`default_nettype wire

[src/baro_pressure_temp_compensation.sv]
`default_nettype none

// Second-order compensation for a barometric pressure and temperature sensor.
//
// The user must load the six factory calibration words through the write port
// (cfg_we, cfg_idx, cfg_data) while the block is idle, which the block does not
// enforce; indexes outside the six are ignored. Each request on the sample
// channel carries one raw temperature conversion and one raw pressure conversion.
// Each produces exactly one request on the result channel with the temperature in
// hundredths of a degree, the pressure in pascals and a flag that is set when
// either value had to be saturated.
// The datapath is a nine-stage pipeline. A sample is registered in stage 1, moves
// through stages 2 to 8 and reaches the result channel from the stage 9 register,
// and one sample can be taken every cycle while the receiver does not stall.
// Every stage holds its own valid bit and moves on when the stage after it is
// empty or moving, so gaps in the stream are squeezed out. When the receiver
// stalls, the final stage holds its result, the stages behind it fill up and the
// sample channel drops ready only once all nine are occupied.
//
// Reset clears the valid bits and sets every calibration word to zero.

module baro_pressure_temp_compensation (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bptc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [bptc_pkg::COEF_W-1:0]    cfg_data,
	bptc_in_if.sink                             sample,
	bptc_out_if.source                          result
);
	import bptc_pkg::*;

	// Calibration words C1 to C6.
	logic [COEF_W-1:0] coef_sens_q;
	logic [COEF_W-1:0] coef_off_q;
	logic [COEF_W-1:0] coef_tcs_q;
	logic [COEF_W-1:0] coef_tco_q;
	logic [COEF_W-1:0] coef_tref_q;
	logic [COEF_W-1:0] coef_tempsens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_sens_q     <= '0;
			coef_off_q      <= '0;
			coef_tcs_q      <= '0;
			coef_tco_q      <= '0;
			coef_tref_q     <= '0;
			coef_tempsens_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SENS:     coef_sens_q     <= cfg_data;
				CFG_OFF:      coef_off_q      <= cfg_data;
				CFG_TCS:      coef_tcs_q      <= cfg_data;
				CFG_TCO:      coef_tco_q      <= cfg_data;
				CFG_TREF:     coef_tref_q     <= cfg_data;
				CFG_TEMPSENS: coef_tempsens_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage flow control. A stage loads when it is empty or its contents move on.
	logic [NSTAGE:1] stage_vld_q;
	logic [NSTAGE:1] stage_en;

	always_comb begin
		stage_en[NSTAGE] = !stage_vld_q[NSTAGE] || result.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				stage_vld_q[1] <= sample.valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign sample.ready = stage_en[1];
	assign result.valid = stage_vld_q[NSTAGE];

	// Stage 1: temperature difference dT = D2 - C5 * 256.
	logic signed [DT_W-1:0] dt_s1;
	logic [RAW_W-1:0]       d1_s1;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			dt_s1 <= $signed({1'b0, sample.raw_temp}) - $signed({1'b0, coef_tref_q, 8'h00});
			d1_s1 <= sample.raw_press;
		end
	end

	// Stage 2: the four products of dT, one multiplier each.
	logic signed [MULT_W-1:0]   prod_t_s2;
	logic signed [MULT_W-1:0]   prod_o_s2;
	logic signed [MULT_W-1:0]   prod_s_s2;
	logic [DTSQ_W-1:0]          dtsq_s2;
	logic [RAW_W-1:0]           d1_s2;
	logic signed [2*DT_W-1:0]   dtsq_full;

	assign dtsq_full = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			prod_t_s2 <= dt_s1 * $signed({1'b0, coef_tempsens_q});
			prod_o_s2 <= dt_s1 * $signed({1'b0, coef_tco_q});
			prod_s_s2 <= dt_s1 * $signed({1'b0, coef_tcs_q});
			dtsq_s2   <= dtsq_full[DTSQ_W-1:0];
			d1_s2     <= d1_s1;
		end
	end

	// Stage 3: first-order TEMP, OFF and SENS, and the T2 term.
	// Arithmetic right shifts of signed values round toward minus infinity.
	logic signed [MULT_W-1:0]  tsh;
	logic signed [MULT_W-1:0]  osh;
	logic signed [MULT_W-1:0]  ssh;
	logic signed [TEMP1_W-1:0] temp1_s3;
	logic signed [OFF1_W-1:0]  off1_s3;
	logic signed [SENS1_W-1:0] sens1_s3;
	logic [T2_W-1:0]           t2_s3;
	logic [RAW_W-1:0]          d1_s3;

	assign tsh = prod_t_s2 >>> 23;
	assign osh = prod_o_s2 >>> 7;
	assign ssh = prod_s_s2 >>> 8;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			temp1_s3 <= $signed(tsh[TEMP1_W-1:0]) + TEMP_REF;
			off1_s3  <= $signed({3'b000, coef_off_q, 16'h0000}) + $signed(osh[OFF1_W-1:0]);
			sens1_s3 <= $signed({3'b000, coef_sens_q, 15'h0000}) + $signed(ssh[SENS1_W-1:0]);
			t2_s3    <= dtsq_s2[DTSQ_W-1:31];
			d1_s3    <= d1_s2;
		end
	end

	// Stage 4: squares of the distances below 20 and below -15 degrees.
	logic signed [TEMP1_W-1:0]   dist_ref;
	logic signed [TEMP1_W-1:0]   dist_deep;
	logic signed [2*TEMP1_W-1:0] sq_full;
	logic signed [2*TEMP1_W-1:0] sq2_full;
	logic [SQ_W-1:0]             sq_s4;
	logic [SQ_W-1:0]             sq2_s4;
	logic                        lt_ref_s4;
	logic                        lt_deep_s4;
	logic signed [TEMP1_W-1:0]   temp1_s4;
	logic signed [OFF1_W-1:0]    off1_s4;
	logic signed [SENS1_W-1:0]   sens1_s4;
	logic [T2_W-1:0]             t2_s4;
	logic [RAW_W-1:0]            d1_s4;

	assign dist_ref  = temp1_s3 - TEMP_REF;
	assign dist_deep = temp1_s3 - TEMP_DEEP;
	assign sq_full   = dist_ref * dist_ref;
	assign sq2_full  = dist_deep * dist_deep;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			sq_s4      <= sq_full[SQ_W-1:0];
			sq2_s4     <= sq2_full[SQ_W-1:0];
			lt_ref_s4  <= temp1_s3 < TEMP_REF;
			lt_deep_s4 <= temp1_s3 < TEMP_DEEP;
			temp1_s4   <= temp1_s3;
			off1_s4    <= off1_s3;
			sens1_s4   <= sens1_s3;
			t2_s4      <= t2_s3;
			d1_s4      <= d1_s3;
		end
	end

	// Stage 5: OFF2 and SENS2 from constant multiples of the squares, and the
	// corrected temperature.
	logic [CORR_W-1:0]         sq_w;
	logic [CORR_W-1:0]         sq2_w;
	logic [CORR_W-1:0]         five_sq;
	logic [CORR_W-1:0]         seven_sq2;
	logic [CORR_W-1:0]         eleven_sq2;
	logic [CORR_W-1:0]         off2_s5;
	logic [CORR_W-1:0]         sens2_s5;
	logic signed [TEMP1_W-1:0] temp2_s5;
	logic                      lt_ref_s5;
	logic signed [OFF1_W-1:0]  off1_s5;
	logic signed [SENS1_W-1:0] sens1_s5;
	logic [RAW_W-1:0]          d1_s5;

	assign sq_w       = CORR_W'(sq_s4);
	assign sq2_w      = CORR_W'(sq2_s4);
	assign five_sq    = (sq_w << 2) + sq_w;
	assign seven_sq2  = (sq2_w << 3) - sq2_w;
	assign eleven_sq2 = (sq2_w << 3) + (sq2_w << 1) + sq2_w;

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			off2_s5   <= (five_sq >> 1) + (lt_deep_s4 ? seven_sq2 : '0);
			sens2_s5  <= (five_sq >> 2) + (lt_deep_s4 ? (eleven_sq2 >> 1) : '0);
			temp2_s5  <= lt_ref_s4 ? temp1_s4 - $signed({3'b000, t2_s4}) : temp1_s4;
			lt_ref_s5 <= lt_ref_s4;
			off1_s5   <= off1_s4;
			sens1_s5  <= sens1_s4;
			d1_s5     <= d1_s4;
		end
	end

	// Stage 6: final OFF and SENS.
	logic signed [OFF_W-1:0]   off1_ext;
	logic signed [SENS_W-1:0]  sens1_ext;
	logic signed [OFF_W-1:0]   off_s6;
	logic signed [SENS_W-1:0]  sens_s6;
	logic signed [TEMP1_W-1:0] temp2_s6;
	logic [RAW_W-1:0]          d1_s6;

	assign off1_ext  = OFF_W'(off1_s5);
	assign sens1_ext = SENS_W'(sens1_s5);

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			off_s6   <= lt_ref_s5 ? off1_ext - $signed({1'b0, off2_s5}) : off1_ext;
			sens_s6  <= lt_ref_s5 ? sens1_ext - $signed({1'b0, sens2_s5}) : sens1_ext;
			temp2_s6 <= temp2_s5;
			d1_s6    <= d1_s5;
		end
	end

	// Stage 7: D1 * SENS split into two partial products on the halves of SENS.
	logic [SPLIT_W-1:0]               sens_lo;
	logic signed [SENS_W-SPLIT_W-1:0] sens_hi;
	logic [PLO_W-1:0]                 plo_s7;
	logic signed [PHI_W-1:0]          phi_s7;
	logic signed [OFF_W-1:0]          off_s7;
	logic signed [TEMP1_W-1:0]        temp2_s7;

	assign sens_lo = sens_s6[SPLIT_W-1:0];
	assign sens_hi = $signed(sens_s6[SENS_W-1:SPLIT_W]);

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			plo_s7   <= d1_s6 * sens_lo;
			phi_s7   <= $signed({1'b0, d1_s6}) * sens_hi;
			off_s7   <= off_s6;
			temp2_s7 <= temp2_s6;
		end
	end

	// Stage 8: the partial products are summed into the full product.
	logic signed [PROD_W-1:0]  prod_s8;
	logic signed [OFF_W-1:0]   off_s8;
	logic signed [TEMP1_W-1:0] temp2_s8;

	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			prod_s8  <= (PROD_W'(phi_s7) <<< SPLIT_W)
				+ $signed({{(PROD_W-PLO_W){1'b0}}, plo_s7});
			off_s8   <= off_s7;
			temp2_s8 <= temp2_s7;
		end
	end

	// Stage 9: pressure, then saturation of both results.
	logic signed [PROD_W-1:0]  prod_sh;
	logic signed [X_W-1:0]     press_raw;
	logic signed [X_W-1:0]     press_sh;
	logic                      press_neg;
	logic                      press_over;
	logic                      temp_under;
	logic                      temp_over;
	logic [PRESS_W-1:0]        press_sat;
	logic signed [TEMP1_W-1:0] temp_sat;
	logic signed [TEMP_W-1:0]  temp_centi_s9;
	logic [PRESS_W-1:0]        press_pa_s9;
	logic                      clipped_s9;

	assign prod_sh    = prod_s8 >>> 21;
	assign press_raw  = $signed(prod_sh[X_W-1:0]) - X_W'(off_s8);
	assign press_sh   = press_raw >>> 15;
	assign press_neg  = press_sh[X_W-1];
	assign press_over = !press_neg && (|press_sh[X_W-2:PRESS_W]);
	assign temp_under = temp2_s8 < TEMP_LO;
	assign temp_over  = temp2_s8 > TEMP_HI;

	always_comb begin
		if (press_neg) begin
			press_sat = '0;
		end else if (press_over) begin
			press_sat = PRESS_MAX;
		end else begin
			press_sat = press_sh[PRESS_W-1:0];
		end
		if (temp_under) begin
			temp_sat = TEMP_LO;
		end else if (temp_over) begin
			temp_sat = TEMP_HI;
		end else begin
			temp_sat = temp2_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			temp_centi_s9 <= temp_sat[TEMP_W-1:0];
			press_pa_s9   <= press_sat;
			clipped_s9    <= press_neg || press_over || temp_under || temp_over;
		end
	end

	assign result.temp_centi = temp_centi_s9;
	assign result.press_pa   = press_pa_s9;
	assign result.clipped    = clipped_s9;

endmodule

`default_nettype wire
